// File: rtl/a4dec_pkg.sv
// shared types, constants and class codes for the arm-state instruction decoder
// no dependencies; imported by every stage module and the top level
`default_nettype none

package a4dec_pkg;

    // instruction class codes as they appear on the result
    localparam logic [5:0] CLS_MUL   = 6'd16;
    localparam logic [5:0] CLS_MLA   = 6'd17;
    localparam logic [5:0] CLS_UMULL = 6'd18;
    localparam logic [5:0] CLS_B     = 6'd22;
    localparam logic [5:0] CLS_BL    = 6'd23;
    localparam logic [5:0] CLS_BX    = 6'd24;
    localparam logic [5:0] CLS_LDR   = 6'd25;
    localparam logic [5:0] CLS_STR   = 6'd26;
    localparam logic [5:0] CLS_LDRH  = 6'd27;
    localparam logic [5:0] CLS_STRH  = 6'd28;
    localparam logic [5:0] CLS_LDRSB = 6'd29;
    localparam logic [5:0] CLS_LDRSH = 6'd30;
    localparam logic [5:0] CLS_LDM   = 6'd31;
    localparam logic [5:0] CLS_STM   = 6'd32;
    localparam logic [5:0] CLS_SWP   = 6'd33;
    localparam logic [5:0] CLS_SWPB  = 6'd34;
    localparam logic [5:0] CLS_MRS   = 6'd35;
    localparam logic [5:0] CLS_MSR   = 6'd36;
    localparam logic [5:0] CLS_SWI   = 6'd37;
    localparam logic [5:0] CLS_UNDEF = 6'd38;

    // halfword sh field codes
    localparam logic [1:0] SH_H  = 2'd1;
    localparam logic [1:0] SH_SB = 2'd2;
    localparam logic [1:0] SH_SH = 2'd3;

    // bit positions within the flag field
    localparam int FL_S  = 0;
    localparam int FL_I  = 1;
    localparam int FL_P  = 2;
    localparam int FL_U  = 3;
    localparam int FL_B  = 4;
    localparam int FL_W  = 5;
    localparam int FL_L  = 6;
    localparam int FL_R  = 7;
    localparam int FL_SR = 8;

    // matching masks and patterns of the miscellaneous group
    localparam logic [31:0] BX_MASK      = 32'h0FFF_FFF0;
    localparam logic [31:0] BX_PAT       = 32'h012F_FF10;
    localparam logic [31:0] MRS_MASK     = 32'h0FBF_0FFF;
    localparam logic [31:0] MRS_PAT      = 32'h010F_0000;
    localparam logic [31:0] MSR_REG_MASK = 32'h0FB0_FFF0;
    localparam logic [31:0] MSR_REG_PAT  = 32'h0120_F000;
    localparam logic [31:0] MSR_IMM_MASK = 32'h0FB0_F000;
    localparam logic [31:0] MSR_IMM_PAT  = 32'h0320_F000;

    localparam logic [3:0] LOW4_MUL = 4'd9;
    localparam logic [3:0] NIB_SWI  = 4'hF;

    localparam int IN_W  = 32;
    localparam int OUT_W = 96;

    // instruction format found by the first stage
    typedef enum logic [3:0] {
        FMT_UNDEF,
        FMT_BX,
        FMT_MRS,
        FMT_MSR,
        FMT_MUL,
        FMT_MULL,
        FMT_SWP,
        FMT_HALF,
        FMT_DP,
        FMT_SINGLE,
        FMT_BRANCH,
        FMT_BLOCK,
        FMT_SWI
    } fmt_t;

    // decoded fields before the immediate rotate
    typedef struct packed {
        logic [5:0]  cls;
        logic [3:0]  cond;
        logic [3:0]  rd;
        logic [3:0]  rn;
        logic [3:0]  rm;
        logic [3:0]  rs;
        logic [31:0] imm;
        logic [3:0]  rot;
        logic [1:0]  skind;
        logic [4:0]  scount;
        logic [8:0]  flags;
        logic [3:0]  mask;
        logic [15:0] list;
    } dec_t;

endpackage

`default_nettype wire

// File: rtl/a4dec_classify.sv
// first pipeline stage: matches the word against the format patterns
// depends on a4dec_pkg
`default_nettype none

module a4dec_classify
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                in_valid,
    output      logic                in_ready,
    input  wire logic [31:0]         in_word,
    output      logic                out_valid,
    input  wire logic                out_ready,
    output      logic [31:0]         out_word,
    output      a4dec_pkg::fmt_t     out_fmt
);
    import a4dec_pkg::*;

    logic        valid_reg;
    logic [31:0] word_reg;
    fmt_t        fmt_reg;
    fmt_t        fmt_next;
    logic [3:0]  low4;

    assign low4 = in_word[7:4];

    always_comb
    begin
        fmt_next = FMT_UNDEF;
        unique case (in_word[27:26])
            2'd0:
            begin
                if ((in_word & BX_MASK) == BX_PAT)
                    fmt_next = FMT_BX;
                else if ((in_word & MRS_MASK) == MRS_PAT)
                    fmt_next = FMT_MRS;
                else if ((in_word & MSR_REG_MASK) == MSR_REG_PAT ||
                         (in_word & MSR_IMM_MASK) == MSR_IMM_PAT)
                    fmt_next = FMT_MSR;
                else if (low4 == LOW4_MUL && in_word[27:22] == 6'd0)
                    fmt_next = FMT_MUL;
                else if (low4 == LOW4_MUL && in_word[27:23] == 5'd1)
                    fmt_next = FMT_MULL;
                else if (low4 == LOW4_MUL && in_word[27:23] == 5'd2 &&
                         in_word[21:20] == 2'd0 && in_word[11:8] == 4'd0)
                    fmt_next = FMT_SWP;
                else if (in_word[7] && in_word[4] && in_word[6:5] != 2'd0)
                begin
                    // stores only know the unsigned halfword form
                    if (in_word[20] || in_word[6:5] == SH_H)
                        fmt_next = FMT_HALF;
                    else
                        fmt_next = FMT_UNDEF;
                end
                else
                    fmt_next = FMT_DP;
            end
            2'd1:
                fmt_next = (in_word[25] && in_word[4]) ? FMT_UNDEF : FMT_SINGLE;
            2'd2:
                fmt_next = in_word[25] ? FMT_BRANCH : FMT_BLOCK;
            2'd3:
                fmt_next = (in_word[27:24] == NIB_SWI) ? FMT_SWI : FMT_UNDEF;
            default:
                fmt_next = FMT_UNDEF;
        endcase
    end

    assign in_ready = !valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (in_ready)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            word_reg <= in_word;
            fmt_reg  <= fmt_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_word  = word_reg;
    assign out_fmt   = fmt_reg;

endmodule

`default_nettype wire

// File: rtl/a4dec_extract.sv
// second pipeline stage: pulls the register numbers, flags and raw immediate
// out of the word for the format found in the first stage; depends on a4dec_pkg
`default_nettype none

module a4dec_extract
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                in_valid,
    output      logic                in_ready,
    input  wire logic [31:0]         in_word,
    input  wire a4dec_pkg::fmt_t     in_fmt,
    output      logic                out_valid,
    input  wire logic                out_ready,
    output      a4dec_pkg::dec_t     out_dec
);
    import a4dec_pkg::*;

    logic        valid_reg;
    dec_t        dec_reg;
    dec_t        dec_next;
    logic [31:0] w;

    assign w = in_word;

    always_comb
    begin
        dec_next      = '0;
        dec_next.cls  = CLS_UNDEF;
        dec_next.cond = w[31:28];
        unique case (in_fmt)
            FMT_BX:
            begin
                dec_next.cls = CLS_BX;
                dec_next.rm  = w[3:0];
            end
            FMT_MRS:
            begin
                dec_next.cls       = CLS_MRS;
                dec_next.flags[FL_R] = w[22];
                dec_next.rd        = w[15:12];
            end
            FMT_MSR:
            begin
                dec_next.cls         = CLS_MSR;
                dec_next.flags[FL_R] = w[22];
                dec_next.mask        = w[19:16];
                if (w[25])
                begin
                    dec_next.flags[FL_I] = 1'b1;
                    dec_next.imm         = {24'd0, w[7:0]};
                    dec_next.rot         = w[11:8];
                end
                else
                    dec_next.rm = w[3:0];
            end
            FMT_MUL:
            begin
                dec_next.cls         = w[21] ? CLS_MLA : CLS_MUL;
                dec_next.flags[FL_S] = w[20];
                dec_next.rd          = w[19:16];
                dec_next.rn          = w[15:12];
                dec_next.rs          = w[11:8];
                dec_next.rm          = w[3:0];
            end
            FMT_MULL:
            begin
                dec_next.cls         = CLS_UMULL + {4'd0, w[22:21]};
                dec_next.flags[FL_S] = w[20];
                dec_next.rn          = w[19:16];
                dec_next.rd          = w[15:12];
                dec_next.rs          = w[11:8];
                dec_next.rm          = w[3:0];
            end
            FMT_SWP:
            begin
                dec_next.cls         = w[22] ? CLS_SWPB : CLS_SWP;
                dec_next.flags[FL_B] = w[22];
                dec_next.rn          = w[19:16];
                dec_next.rd          = w[15:12];
                dec_next.rm          = w[3:0];
            end
            FMT_HALF:
            begin
                if (!w[20])
                    dec_next.cls = CLS_STRH;
                else if (w[6:5] == SH_SB)
                    dec_next.cls = CLS_LDRSB;
                else if (w[6:5] == SH_SH)
                    dec_next.cls = CLS_LDRSH;
                else
                    dec_next.cls = CLS_LDRH;
                dec_next.flags[FL_P] = w[24];
                dec_next.flags[FL_U] = w[23];
                dec_next.flags[FL_W] = w[21];
                dec_next.rn          = w[19:16];
                dec_next.rd          = w[15:12];
                if (w[22])
                begin
                    dec_next.flags[FL_I] = 1'b1;
                    dec_next.imm         = {24'd0, w[11:8], w[3:0]};
                end
                else
                    dec_next.rm = w[3:0];
            end
            FMT_DP:
            begin
                dec_next.cls         = {2'd0, w[24:21]};
                dec_next.flags[FL_S] = w[20];
                dec_next.rn          = w[19:16];
                dec_next.rd          = w[15:12];
                if (w[25])
                begin
                    dec_next.flags[FL_I] = 1'b1;
                    dec_next.imm         = {24'd0, w[7:0]};
                    dec_next.rot         = w[11:8];
                end
                else
                begin
                    dec_next.rm    = w[3:0];
                    dec_next.skind = w[6:5];
                    if (w[4])
                    begin
                        dec_next.flags[FL_SR] = 1'b1;
                        dec_next.rs           = w[11:8];
                    end
                    else
                        dec_next.scount = w[11:7];
                end
            end
            FMT_SINGLE:
            begin
                dec_next.cls         = w[20] ? CLS_LDR : CLS_STR;
                dec_next.flags[FL_L] = w[20];
                dec_next.flags[FL_I] = w[25];
                dec_next.flags[FL_P] = w[24];
                dec_next.flags[FL_U] = w[23];
                dec_next.flags[FL_B] = w[22];
                dec_next.flags[FL_W] = w[21];
                dec_next.rn          = w[19:16];
                dec_next.rd          = w[15:12];
                if (w[25])
                begin
                    dec_next.rm     = w[3:0];
                    dec_next.skind  = w[6:5];
                    dec_next.scount = w[11:7];
                end
                else
                    dec_next.imm = {20'd0, w[11:0]};
            end
            FMT_BRANCH:
            begin
                dec_next.cls         = w[24] ? CLS_BL : CLS_B;
                dec_next.flags[FL_L] = w[24];
                dec_next.imm         = {{6{w[23]}}, w[23:0], 2'b00};
            end
            FMT_BLOCK:
            begin
                dec_next.cls         = w[20] ? CLS_LDM : CLS_STM;
                dec_next.flags[FL_L] = w[20];
                dec_next.flags[FL_P] = w[24];
                dec_next.flags[FL_U] = w[23];
                dec_next.flags[FL_S] = w[22];
                dec_next.flags[FL_W] = w[21];
                dec_next.rn          = w[19:16];
                dec_next.list        = w[15:0];
            end
            FMT_SWI:
            begin
                dec_next.cls = CLS_SWI;
                dec_next.imm = {8'd0, w[23:0]};
            end
            default:
            begin
                dec_next.cls = CLS_UNDEF;
            end
        endcase
    end

    assign in_ready = !valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (in_ready)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
            dec_reg <= dec_next;
    end

    assign out_valid = valid_reg;
    assign out_dec   = dec_reg;

endmodule

`default_nettype wire

// File: rtl/a4dec_finish.sv
// third pipeline stage: rotates the 8-bit immediate and packs the result word
// into the output register; depends on a4dec_pkg
`default_nettype none

module a4dec_finish
(
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    in_valid,
    output      logic                    in_ready,
    input  wire a4dec_pkg::dec_t         in_dec,
    output      logic                    out_valid,
    input  wire logic                    out_ready,
    output      logic [a4dec_pkg::OUT_W-1:0] out_data
);
    import a4dec_pkg::*;

    logic             valid_reg;
    logic [OUT_W-1:0] data_reg;
    logic [OUT_W-1:0] data_next;
    logic [4:0]       rot_amt;
    logic [63:0]      imm_dbl;
    logic [63:0]      imm_shr;
    logic [31:0]      imm_final;

    // rotate right by twice the rotate nibble; zero nibble leaves the value
    assign rot_amt   = {in_dec.rot, 1'b0};
    assign imm_dbl   = {in_dec.imm, in_dec.imm};
    assign imm_shr   = imm_dbl >> rot_amt;
    assign imm_final = imm_shr[31:0];

    assign data_next = {2'b00,
                        in_dec.list,
                        in_dec.mask,
                        in_dec.flags,
                        in_dec.scount,
                        in_dec.skind,
                        imm_final,
                        in_dec.rs,
                        in_dec.rm,
                        in_dec.rn,
                        in_dec.rd,
                        in_dec.cond,
                        in_dec.cls};

    assign in_ready = !valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (in_ready)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
            data_reg <= data_next;
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

`default_nettype wire

// File: rtl/armv4_instruction_decoder.sv
// top level of the arm-state (armv4t) instruction decoder: three register stages
// depends on a4dec_pkg, a4dec_classify, a4dec_extract, a4dec_finish
//
//  channel  | direction | payload
//  ---------+-----------+---------------------------------------------------
//  s_t*     | in        | tdata[31:0] instruction word
//  m_t*     | out       | tdata[95:0] decoded instruction, fields below
//
// one instruction word per cycle sustained while m_tready is high; each word passes
// through the stages in order (classify, field extract, immediate rotate and pack)
// the last stage register is the output register, so a result waiting
// on m_tready does not stop the front stages from filling
// m_tready reaches s_tready through the stage ready terms in the same cycle;
// a stage with an empty register keeps taking words, so bubbles close up and
// the input stalls only once all three stages hold a word
// every stage holds its contents under a stall, so nothing is dropped or repeated
// reset clears only the stage valid bits; payload registers are not reset
`default_nettype none

module armv4_instruction_decoder
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    // instruction word transfer
    input  wire logic        s_tvalid,
    output      logic        s_tready,
    input  wire logic [31:0] s_tdata,   // [31:0] instruction_word
    // decoded result transfer
    output      logic        m_tvalid,
    input  wire logic        m_tready,
    output      logic [95:0] m_tdata    // [5:0] insn_class, [9:6] condition_code,
                                        // [13:10] dest_reg, [17:14] base_reg,
                                        // [21:18] operand_reg, [25:22] shift_reg_num,
                                        // [57:26] immediate_value, [59:58] shift_kind,
                                        // [64:60] shift_count, [73:65] flag_bits,
                                        // [77:74] psr_field_mask,
                                        // [93:78] register_list, [95:94] zero
);
    import a4dec_pkg::*;

    // classify -> extract
    logic        c_valid;
    logic        c_ready;
    logic [31:0] c_word;
    fmt_t        c_fmt;

    // extract -> finish
    logic        e_valid;
    logic        e_ready;
    dec_t        e_dec;

    // stage 1: pattern match in the documented priority order
    a4dec_classify u_classify
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_word   (s_tdata),
        .out_valid (c_valid),
        .out_ready (c_ready),
        .out_word  (c_word),
        .out_fmt   (c_fmt)
    );

    // stage 2: register numbers, flags and raw immediate per format
    a4dec_extract u_extract
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (c_valid),
        .in_ready  (c_ready),
        .in_word   (c_word),
        .in_fmt    (c_fmt),
        .out_valid (e_valid),
        .out_ready (e_ready),
        .out_dec   (e_dec)
    );

    // stage 3: immediate rotate, pack and hold for the output transfer
    a4dec_finish u_finish
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (e_valid),
        .in_ready  (e_ready),
        .in_dec    (e_dec),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (m_tdata)
    );

endmodule

`default_nettype wire
